@@ src/scull_pkg.sv @@
// shared constants and types for the shadow caster plane cull block
package scull_pkg;

  localparam int MaxPlanes      = 6;
  localparam int CoordBits      = 16;
  localparam int CountBits      = 16;
  localparam int PlaneFieldBits = 16;
  localparam int PlaneBits      = 4 * PlaneFieldBits;
  localparam int PlaneCntBits   = 3;
  localparam int CfgIdxBits     = 3;
  localparam int PlaneIdxBits   = $clog2(MaxPlanes);
  localparam int NumAxes        = 3;
  localparam int DistShift      = 8;

  // Q8.8 * Q8.8 gives Q16.16, four terms need two guard bits
  localparam int ProdBits = PlaneFieldBits + CoordBits;
  localparam int SumBits  = ProdBits + 2;

  typedef logic signed [CoordBits-1:0]      coord_t;
  typedef logic signed [PlaneFieldBits-1:0] pfield_t;
  typedef logic signed [ProdBits-1:0]       prod_t;
  typedef logic signed [SumBits-1:0]        sum_t;
  typedef logic [CountBits-1:0]             count_t;
  typedef logic [PlaneCntBits-1:0]          plane_cnt_t;

  // packed from the low bits up: normal x, y, z, then distance
  typedef struct packed {
    pfield_t offs;
    pfield_t nz;
    pfield_t ny;
    pfield_t nx;
  } plane_t;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_PLANE_COUNT = 3'd0,
    REG_PLANE_ZERO  = 3'd1,
    REG_PLANE_ONE   = 3'd2,
    REG_PLANE_TWO   = 3'd3,
    REG_PLANE_THREE = 3'd4,
    REG_PLANE_FOUR  = 3'd5,
    REG_PLANE_FIVE  = 3'd6
  } cfg_reg_e;

  localparam count_t CountMax = '1;

endpackage

@@ src/shadow_caster_aabb_plane_cull.sv @@
// shadow caster box culling against up to six planes with the p-vertex test
// path: an accepted input beat passes the input, product and result registers before its result beat
// throughput: one beat per cycle while out_stall_i is low; input, product and result registers each move on
// when the stage behind them is empty or drains, so bubbles close under a stall
// the eighteen plane-axis multiplies fill one stage, the four-term sum and sign test the next
// reset: valids, candidate count and all configuration registers clear to zero
module shadow_caster_aabb_plane_cull (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [scull_pkg::CfgIdxBits-1:0]       cfg_idx_i,
  input  logic [scull_pkg::PlaneBits-1:0]        cfg_wdata_i,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic                                   casts_shadow_i,
  input  logic [7:0]                             render_bits_i,
  input  logic signed [scull_pkg::CoordBits-1:0] box_min_x_i,
  input  logic signed [scull_pkg::CoordBits-1:0] box_min_y_i,
  input  logic signed [scull_pkg::CoordBits-1:0] box_min_z_i,
  input  logic signed [scull_pkg::CoordBits-1:0] box_max_x_i,
  input  logic signed [scull_pkg::CoordBits-1:0] box_max_y_i,
  input  logic signed [scull_pkg::CoordBits-1:0] box_max_z_i,
  input  logic                                   last_node_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic                                   is_candidate_o,
  output logic                                   visible_o,
  output logic [scull_pkg::CountBits-1:0]        candidate_total_o,
  output logic                                   list_end_o
);
  import scull_pkg::*;

  // configuration
  plane_cnt_t plane_cnt_q;
  plane_t     plane_q [MaxPlanes];
  logic [CfgIdxBits-1:0] cfg_slot;

  // pipeline control
  logic in_acc, s1_adv, s2_adv, out_adv;

  // input stage
  logic   s1_valid_q, s1_cand_q, s1_last_q;
  count_t s1_total_q;
  coord_t s1_min_q [NumAxes];
  coord_t s1_max_q [NumAxes];

  // product stage
  logic   s2_valid_q, s2_cand_q, s2_last_q;
  count_t s2_total_q;
  prod_t  prod_d [MaxPlanes][NumAxes];
  prod_t  s2_prod_q [MaxPlanes][NumAxes];

  // result stage
  logic   out_valid_q, out_cand_q, out_vis_q, out_last_q;
  count_t out_total_q;
  logic   vis_d;

  // counter
  count_t cnt_q, cnt_d, total_d;
  logic   cand_d;

  plane_cnt_t active_cnt;

  assign out_adv    = !out_valid_q || !out_stall_i;
  assign s2_adv     = !s2_valid_q || out_adv;
  assign s1_adv     = !s1_valid_q || s2_adv;
  assign in_stall_o = !s1_adv;
  assign in_acc     = in_valid_i && s1_adv;

  assign cfg_slot = cfg_idx_i - CfgIdxBits'(REG_PLANE_ZERO);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_cnt_q <= '0;
      for (int j = 0; j < MaxPlanes; j++) begin
        plane_q[j] <= '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_PLANE_COUNT) begin
        plane_cnt_q <= cfg_wdata_i[PlaneCntBits-1:0];
      end else if (cfg_idx_i inside {[REG_PLANE_ZERO:REG_PLANE_FIVE]}) begin
        plane_q[cfg_slot[PlaneIdxBits-1:0]] <= cfg_wdata_i;
      end
    end
  end

  // candidate filter and running count, settled at acceptance
  always_comb begin
    cand_d = casts_shadow_i && (render_bits_i == '0);
    total_d = cnt_q;
    if (cand_d && (cnt_q != CountMax)) begin
      total_d = cnt_q + count_t'(1);
    end
    cnt_d = cnt_q;
    if (in_acc) begin
      cnt_d = last_node_i ? '0 : total_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (s1_adv) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_adv) begin
        s2_valid_q <= s1_valid_q;
      end
      if (out_adv) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_cand_q   <= cand_d;
      s1_last_q   <= last_node_i;
      s1_total_q  <= total_d;
      s1_min_q[0] <= box_min_x_i;
      s1_min_q[1] <= box_min_y_i;
      s1_min_q[2] <= box_min_z_i;
      s1_max_q[0] <= box_max_x_i;
      s1_max_q[1] <= box_max_y_i;
      s1_max_q[2] <= box_max_z_i;
    end
  end

  // p-vertex select and one multiply per plane and axis
  always_comb begin
    pfield_t nrm [NumAxes];
    coord_t  pv;
    for (int j = 0; j < MaxPlanes; j++) begin
      nrm[0] = plane_q[j].nx;
      nrm[1] = plane_q[j].ny;
      nrm[2] = plane_q[j].nz;
      for (int a = 0; a < NumAxes; a++) begin
        pv = nrm[a][PlaneFieldBits-1] ? s1_min_q[a] : s1_max_q[a];
        prod_d[j][a] = prod_t'(nrm[a]) * prod_t'(pv);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s2_adv) begin
      s2_cand_q  <= s1_cand_q;
      s2_last_q  <= s1_last_q;
      s2_total_q <= s1_total_q;
      s2_prod_q  <= prod_d;
    end
  end

  // distance plus products, sign test over the active planes
  assign active_cnt = (plane_cnt_q > plane_cnt_t'(MaxPlanes)) ?
                      plane_cnt_t'(MaxPlanes) : plane_cnt_q;

  always_comb begin
    sum_t s;
    vis_d = s2_cand_q;
    for (int j = 0; j < MaxPlanes; j++) begin
      s = $signed({{(SumBits-PlaneFieldBits-DistShift){plane_q[j].offs[PlaneFieldBits-1]}},
                   plane_q[j].offs, {DistShift{1'b0}}})
          + sum_t'(s2_prod_q[j][0]) + sum_t'(s2_prod_q[j][1]) + sum_t'(s2_prod_q[j][2]);
      if ((plane_cnt_t'(j) < active_cnt) && s[SumBits-1]) begin
        vis_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_valid_q && out_adv) begin
      out_cand_q  <= s2_cand_q;
      out_vis_q   <= vis_d;
      out_last_q  <= s2_last_q;
      out_total_q <= s2_total_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign is_candidate_o    = out_cand_q;
  assign visible_o         = out_vis_q;
  assign candidate_total_o = out_total_q;
  assign list_end_o        = out_last_q;

`ifndef ASSERT_OFF
  a_vis_needs_cand: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!visible_o || is_candidate_o))
    else $error("visible set on a non-candidate beat");

  a_cand_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_candidate_o) |-> (candidate_total_o != '0))
    else $error("candidate beat shows a zero count");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && last_node_i) |=> (cnt_q == '0))
    else $error("count not cleared after the last node");

  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> !in_stall_o)
    else $error("input stalled while the result register is empty");
`endif

endmodule

@@ tb/shadow_caster_aabb_plane_cull_tb.sv @@
// testbench for the shadow caster plane cull block: predicted results checked beat by beat
`timescale 1ns / 100ps

module shadow_caster_aabb_plane_cull_tb;
  import scull_pkg::*;

  localparam int CycleLimit   = 1_000_000;
  localparam int SettleCycles = 8;
  localparam int MaxReported  = 10;
  localparam int CountRunLen  = 200;
  localparam int PhaseItems   = 160;
  localparam logic [CfgIdxBits-1:0] RegUnused = 3'd7;
  localparam coord_t  CoordLo = 16'h8000;
  localparam coord_t  CoordHi = 16'h7FFF;
  localparam pfield_t FieldLo = 16'h8000;
  localparam pfield_t FieldHi = 16'h7FFF;

  typedef struct packed {
    logic       casts_shadow;
    logic [7:0] render_bits;
    coord_t     min_x;
    coord_t     min_y;
    coord_t     min_z;
    coord_t     max_x;
    coord_t     max_y;
    coord_t     max_z;
    logic       last_node;
  } node_t;

  typedef struct packed {
    logic   is_candidate;
    logic   visible;
    count_t candidate_total;
    logic   list_end;
  } cull_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CfgIdxBits-1:0] cfg_idx_i;
  logic [PlaneBits-1:0]  cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic                  casts_shadow_i;
  logic [7:0]            render_bits_i;
  coord_t                box_min_x_i;
  coord_t                box_min_y_i;
  coord_t                box_min_z_i;
  coord_t                box_max_x_i;
  coord_t                box_max_y_i;
  coord_t                box_max_z_i;
  logic                  last_node_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic                  is_candidate_o;
  logic                  visible_o;
  count_t                candidate_total_o;
  logic                  list_end_o;

  shadow_caster_aabb_plane_cull dut (.*);

  // shadow copy of the block's configuration and count
  plane_cnt_t active_planes;
  plane_t     plane_set [MaxPlanes];
  count_t     running_count;

  cull_result_t pending_results [$];
  bit           idle_on;
  int           stall_left;
  int           fail_count;
  int           reported;
  int           cycle_count;

  always #6 clk_i = ~clk_i;

  function automatic longint axis_term(input pfield_t n, input coord_t lo, input coord_t hi);
    return longint'(n) * longint'(n < 0 ? lo : hi);
  endfunction

  function automatic cull_result_t cull_node(input node_t nd);
    cull_result_t r;
    int           n;
    longint       s;
    r.is_candidate = nd.casts_shadow && (nd.render_bits == 8'h00);
    r.visible      = 1'b0;
    if (r.is_candidate) begin
      n = (active_planes > MaxPlanes) ? MaxPlanes : int'(active_planes);
      r.visible = 1'b1;
      for (int j = 0; j < n; j++) begin
        s = longint'(plane_set[j].offs) * 256
          + axis_term(plane_set[j].nx, nd.min_x, nd.max_x)
          + axis_term(plane_set[j].ny, nd.min_y, nd.max_y)
          + axis_term(plane_set[j].nz, nd.min_z, nd.max_z);
        if (s < 0) r.visible = 1'b0;
      end
      if (running_count != CountMax) running_count++;
    end
    r.candidate_total = running_count;
    r.list_end        = nd.last_node;
    if (nd.last_node) running_count = '0;
    return r;
  endfunction

  function automatic plane_t make_plane(input pfield_t nx, input pfield_t ny,
                                        input pfield_t nz, input pfield_t offs);
    return {offs, nz, ny, nx};
  endfunction

  function automatic node_t make_node(input logic cs, input logic [7:0] rb,
                                      input coord_t mnx, input coord_t mny, input coord_t mnz,
                                      input coord_t mxx, input coord_t mxy, input coord_t mxz,
                                      input logic last);
    return {cs, rb, mnx, mny, mnz, mxx, mxy, mxz, last};
  endfunction

  // extremes and zero show up often
  function automatic logic [15:0] biased_word();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic plane_t random_plane();
    return {biased_word(), biased_word(), biased_word(), biased_word()};
  endfunction

  function automatic node_t random_node();
    node_t  nd;
    coord_t lo [3];
    coord_t hi [3];
    coord_t t;
    for (int k = 0; k < 3; k++) begin
      lo[k] = biased_word();
      hi[k] = biased_word();
      // mostly well-formed boxes, a few with min above max
      if (lo[k] > hi[k] && $urandom_range(0, 7) != 0) begin
        t = lo[k];
        lo[k] = hi[k];
        hi[k] = t;
      end
    end
    nd.casts_shadow = ($urandom_range(0, 3) != 0);
    nd.render_bits  = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'h00;
    nd.min_x = lo[0];
    nd.min_y = lo[1];
    nd.min_z = lo[2];
    nd.max_x = hi[0];
    nd.max_y = hi[1];
    nd.max_z = hi[2];
    nd.last_node = ($urandom_range(0, 31) == 0);
    return nd;
  endfunction

  task automatic write_reg(input logic [CfgIdxBits-1:0] idx, input logic [PlaneBits-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    if (idx == REG_PLANE_COUNT) begin
      active_planes = data[PlaneCntBits-1:0];
    end else if (idx >= REG_PLANE_ZERO && idx <= REG_PLANE_FIVE) begin
      plane_set[idx - REG_PLANE_ZERO] = data;
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_plane(input int j, input plane_t p);
    write_reg(CfgIdxBits'(int'(REG_PLANE_ZERO) + j), p);
  endtask

  task automatic send_node(input node_t nd);
    int gap;
    gap = idle_on ? $urandom_range(0, 11) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    casts_shadow_i <= nd.casts_shadow;
    render_bits_i  <= nd.render_bits;
    box_min_x_i    <= nd.min_x;
    box_min_y_i    <= nd.min_y;
    box_min_z_i    <= nd.min_z;
    box_max_x_i    <= nd.max_x;
    box_max_y_i    <= nd.max_y;
    box_max_z_i    <= nd.max_z;
    last_node_i    <= nd.last_node;
    in_valid_i     <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // sender holds off until every outstanding result is back
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : beat_monitor
    cull_result_t want;
    cull_result_t got;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      pending_results.push_back(cull_node({casts_shadow_i, render_bits_i,
                                           box_min_x_i, box_min_y_i, box_min_z_i,
                                           box_max_x_i, box_max_y_i, box_max_z_i,
                                           last_node_i}));
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {is_candidate_o, visible_o, candidate_total_o, list_end_o};
      stall_left = idle_on ? $urandom_range(0, 11) : 0;
      if (pending_results.size() == 0) begin
        fail_count++;
        if (reported < MaxReported) begin
          reported++;
          $display("%0t: result beat with nothing expected: cand=%0d vis=%0d total=%0d end=%0d",
                   $realtime, got.is_candidate, got.visible, got.candidate_total,
                   got.list_end);
        end
      end else begin
        want = pending_results.pop_front();
        if (got.is_candidate !== want.is_candidate || got.visible !== want.visible ||
            got.candidate_total !== want.candidate_total || got.list_end !== want.list_end) begin
          fail_count++;
          if (reported < MaxReported) begin
            reported++;
            $display("%0t: mismatch expected cand=%0d vis=%0d total=%0d end=%0d",
                     $realtime, want.is_candidate, want.visible, want.candidate_total,
                     want.list_end);
            $display("%0t:          actual   cand=%0d vis=%0d total=%0d end=%0d",
                     $realtime, got.is_candidate, got.visible, got.candidate_total,
                     got.list_end);
          end
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAIL shadow_caster_aabb_plane_cull");
      $finish;
    end
  end

  // shadow flag, render bits and count clearing with no planes active
  task automatic test_candidate_filter();
    send_node(make_node(1'b0, 8'h00, CoordLo, CoordLo, CoordLo, CoordHi, CoordHi, CoordHi, 1'b0));
    send_node(make_node(1'b1, 8'hFF, CoordLo, CoordLo, CoordLo, CoordHi, CoordHi, CoordHi, 1'b0));
    send_node(make_node(1'b1, 8'h01, 0, 0, 0, 0, 0, 0, 1'b0));
    send_node(make_node(1'b1, 8'h00, CoordHi, CoordHi, CoordHi, CoordLo, CoordLo, CoordLo, 1'b0));
    send_node(make_node(1'b1, 8'h00, 0, 0, 0, 0, 0, 0, 1'b1));
    send_node(make_node(1'b0, 8'h80, 0, 0, 0, 0, 0, 0, 1'b1));
    send_node(make_node(1'b1, 8'h00, CoordLo, CoordLo, CoordLo, CoordHi, CoordHi, CoordHi, 1'b0));
    drain_results();
  endtask

  // all six planes at extreme or zero values, plane count above the maximum, unmapped index
  task automatic test_plane_extremes();
    write_plane(0, make_plane(FieldHi, FieldHi, FieldHi, FieldHi));
    write_plane(1, make_plane(FieldLo, FieldLo, FieldLo, FieldHi));
    write_plane(2, make_plane(FieldLo, FieldHi, 0, 0));
    write_plane(3, make_plane(0, 0, 0, 0));
    write_plane(4, make_plane(FieldHi, FieldLo, FieldHi, FieldLo));
    write_plane(5, make_plane(0, 0, FieldLo, FieldHi));
    write_reg(REG_PLANE_COUNT, PlaneBits'(6));
    send_node(make_node(1'b1, 8'h00, CoordLo, CoordLo, CoordLo, CoordHi, CoordHi, CoordHi, 1'b0));
    send_node(make_node(1'b1, 8'h00, CoordHi, CoordHi, CoordHi, CoordLo, CoordLo, CoordLo, 1'b0));
    send_node(make_node(1'b1, 8'h00, 0, 0, 0, 0, 0, 0, 1'b0));
    send_node(make_node(1'b1, 8'h10, CoordLo, CoordLo, CoordLo, CoordHi, CoordHi, CoordHi, 1'b0));
    send_node(make_node(1'b1, 8'h00, CoordLo, CoordHi, CoordLo, CoordHi, CoordHi, 0, 1'b1));
    drain_results();
    write_reg(REG_PLANE_COUNT, PlaneBits'(7));
    send_node(make_node(1'b1, 8'h00, CoordLo, CoordLo, CoordLo, CoordHi, CoordHi, CoordHi, 1'b0));
    send_node(make_node(1'b1, 8'h00, 0, 0, 0, 0, 0, 0, 1'b0));
    send_node(make_node(1'b1, 8'h00, CoordHi, CoordHi, CoordHi, CoordLo, CoordLo, CoordLo, 1'b0));
    drain_results();
    // write to an unmapped index must leave every plane as it was
    write_reg(RegUnused, '1);
    send_node(make_node(1'b1, 8'h00, CoordLo, CoordLo, CoordLo, CoordHi, CoordHi, CoordHi, 1'b0));
    send_node(make_node(1'b1, 8'h00, 0, 0, 0, 0, 0, 0, 1'b1));
    drain_results();
  endtask

  // plane sum exactly zero counts as inside, one lsb beyond does not
  task automatic test_dot_boundary();
    write_reg(REG_PLANE_COUNT, PlaneBits'(1));
    write_plane(0, make_plane(16'sd256, 0, 0, -16'sd256));
    send_node(make_node(1'b1, 8'h00, 0, 0, 0, 16'sd256, 0, 0, 1'b0));
    send_node(make_node(1'b1, 8'h00, 0, 0, 0, 16'sd255, 0, 0, 1'b0));
    drain_results();
    write_plane(0, make_plane(-16'sd256, 0, 0, 16'sd256));
    send_node(make_node(1'b1, 8'h00, 16'sd256, 0, 0, CoordHi, 0, 0, 1'b0));
    send_node(make_node(1'b1, 8'h00, 16'sd257, 0, 0, CoordHi, 0, 0, 1'b1));
    drain_results();
  endtask

  // run of candidates with no list end, back to back
  task automatic test_count_run();
    node_t nd;
    idle_on = 1'b0;
    for (int i = 0; i < CountRunLen; i++) begin
      nd = random_node();
      nd.casts_shadow = 1'b1;
      nd.render_bits  = 8'h00;
      nd.last_node    = 1'b0;
      send_node(nd);
    end
    nd.last_node = 1'b1;
    send_node(nd);
    nd.last_node = 1'b0;
    send_node(nd);
    drain_results();
  endtask

  task automatic test_random_traffic();
    int phase_planes [8] = '{1, 3, 6, 7, 2, 5, 4, 0};
    for (int ph = 0; ph < 8; ph++) begin
      for (int j = 0; j < MaxPlanes; j++) write_plane(j, random_plane());
      write_reg(REG_PLANE_COUNT, PlaneBits'(phase_planes[ph]));
      idle_on = (ph % 3 != 2);
      for (int i = 0; i < PhaseItems; i++) begin
        if (ph == 1 && i == 95) drain_results();
        send_node(random_node());
      end
      drain_results();
    end
  endtask

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    casts_shadow_i = 1'b0;
    render_bits_i  = '0;
    box_min_x_i    = '0;
    box_min_y_i    = '0;
    box_min_z_i    = '0;
    box_max_x_i    = '0;
    box_max_y_i    = '0;
    box_max_z_i    = '0;
    last_node_i    = 1'b0;
    out_stall_i    = 1'b0;
    active_planes  = '0;
    running_count  = '0;
    for (int j = 0; j < MaxPlanes; j++) plane_set[j] = '0;
    idle_on        = 1'b1;
    stall_left     = 0;
    fail_count     = 0;
    reported       = 0;
    cycle_count    = 0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_candidate_filter();
    test_plane_extremes();
    test_dot_boundary();
    test_count_run();
    test_random_traffic();

    if (fail_count == 0) begin
      $display("PASS shadow_caster_aabb_plane_cull");
    end else begin
      $display("FAIL shadow_caster_aabb_plane_cull");
    end
    $finish;
  end

endmodule
